### src/ffba_pkg.sv
// Shared constants, codes and types for the first-fit block allocator.
// Depends on nothing; every other file in src/ refers to it by scoped names.
package ffba_pkg;

  // Table capacity (valid range 1 to 16, as the block index is INDEX_W = 4 bits wide).
  localparam int MAX_BLOCKS = 16;
  // The counter can hold the capacity itself; the table index only needs the depth.
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  localparam int SIZE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // Command codes carried on the input tuser.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_ALLOC  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED    = 2'd0,
    ST_ALLOCATED = 2'd1,
    ST_NO_FIT    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  // Verdict of the shared fit unit for one table entry.
  typedef struct packed {
    logic              fit;
    logic [SIZE_W-1:0] leftover;
  } fit_res_t;

endpackage

### src/first_fit_block_allocator.sv
// First-fit block allocator, top level. Depends on ffba_pkg, ffba_size_mem and ffba_fit_unit.
// A table of up to MAX_BLOCKS fixed memory blocks is loaded one size at a time: a beat with
// tuser = append stores the size at the next free position and answers "loaded" with that
// position, or "table full" once MAX_BLOCKS blocks are in. A beat with tuser = allocate scans
// the loaded blocks in index order and takes the first one that is free and at least as large
// as the request; it answers "allocated" with the index and the leftover (size minus request),
// or "no fit" with index and leftover zero. Taken blocks stay taken until reset. Every input
// beat produces exactly one output beat. An append goes to the result register on acceptance;
// an allocate scans until a hit or the end of the loaded blocks, reading one size entry per
// cycle through the single registered read port of the size store and feeding it to one
// shared compare-and-subtract unit. The block takes one item at a time; a result may wait in
// the output register while the next beat is accepted.
module first_fit_block_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // Input beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ffba_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [15:0] size_value
  input  logic                              s_axis_tuser,  // [0] command
  // Result beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ffba_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [3:0] block_index, [19:4] leftover
  output logic [ffba_pkg::STATUS_W-1:0]     m_axis_tuser   // [1:0] status
);

  ffba_pkg::state_t state;

  // Table bookkeeping
  logic [ffba_pkg::CNT_W-1:0]      loaded;
  logic [ffba_pkg::MAX_BLOCKS-1:0] taken;

  // Scan state: scan_idx is the address being read, chk_idx the entry whose size is back
  logic [ffba_pkg::CNT_W-1:0]  scan_idx;
  logic [ffba_pkg::CNT_W-1:0]  chk_idx;
  logic                        chk_valid;
  logic [ffba_pkg::SIZE_W-1:0] request;

  // Pending result and output register
  ffba_pkg::status_t           res_status;
  logic [ffba_pkg::INDEX_W-1:0] res_index;
  logic [ffba_pkg::SIZE_W-1:0] res_left;
  logic                        out_valid;
  ffba_pkg::status_t           out_status;
  logic [ffba_pkg::INDEX_W-1:0] out_index;
  logic [ffba_pkg::SIZE_W-1:0] out_left;

  logic                        in_beat;
  logic                        table_full;
  logic                        mem_wr_en;
  logic                        issue;
  logic                        hit;
  logic                        load_out;
  logic [ffba_pkg::SIZE_W-1:0] rd_size;
  ffba_pkg::fit_res_t          fit;

  assign s_axis_tready = (state == ffba_pkg::S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign table_full    = (loaded == ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS));
  assign mem_wr_en     = in_beat && (s_axis_tuser == ffba_pkg::CMD_APPEND) && !table_full;

  // Issue a read while loaded entries remain; the compare follows in the next cycle, on the registered read data.
  assign issue = (state == ffba_pkg::S_SCAN) && (scan_idx < loaded);
  assign hit   = (state == ffba_pkg::S_SCAN) && chk_valid && fit.fit;

  // Move the pending result into the output register once that register is free
  assign load_out = (state == ffba_pkg::S_RESULT) && (!out_valid || m_axis_tready);

  ffba_size_mem u_size_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (loaded[ffba_pkg::IDX_W-1:0]),
    .wr_data (s_axis_tdata[ffba_pkg::SIZE_W-1:0]),
    .rd_addr (scan_idx[ffba_pkg::IDX_W-1:0]),
    .rd_data (rd_size)
  );

  ffba_fit_unit u_fit_unit (
    .block_size (rd_size),
    .request    (request),
    .taken      (taken[chk_idx[ffba_pkg::IDX_W-1:0]]),
    .res        (fit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffba_pkg::S_IDLE;
      loaded    <= '0;
      taken     <= '0;
      scan_idx  <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Take a new result, or drop the old one once the sink takes it
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ffba_pkg::S_IDLE: begin
          if (in_beat) begin
            if (s_axis_tuser == ffba_pkg::CMD_APPEND) begin
              if (table_full) begin
                res_status <= ffba_pkg::ST_FULL;
                res_index  <= '0;
                res_left   <= '0;
              end else begin
                res_status <= ffba_pkg::ST_LOADED;
                res_index  <= ffba_pkg::INDEX_W'(loaded);
                res_left   <= '0;
                taken[loaded[ffba_pkg::IDX_W-1:0]] <= 1'b0;
                loaded     <= loaded + 1'b1;
              end
              state <= ffba_pkg::S_RESULT;
            end else begin
              request   <= s_axis_tdata[ffba_pkg::SIZE_W-1:0];
              scan_idx  <= '0;
              chk_valid <= 1'b0;
              state     <= ffba_pkg::S_SCAN;
            end
          end
        end

        ffba_pkg::S_SCAN: begin
          chk_valid <= issue;
          chk_idx   <= scan_idx;
          if (issue) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (hit) begin
            // First free block that is large enough: claim it
            taken[chk_idx[ffba_pkg::IDX_W-1:0]] <= 1'b1;
            res_status <= ffba_pkg::ST_ALLOCATED;
            res_index  <= ffba_pkg::INDEX_W'(chk_idx);
            res_left   <= fit.leftover;
            state      <= ffba_pkg::S_RESULT;
          end else if (!issue && !chk_valid) begin
            // Nothing left in flight and nothing matched
            res_status <= ffba_pkg::ST_NO_FIT;
            res_index  <= '0;
            res_left   <= '0;
            state      <= ffba_pkg::S_RESULT;
          end
        end

        ffba_pkg::S_RESULT: begin
          // Hold until the output register is free
          if (load_out) begin
            out_status <= res_status;
            out_index  <= res_index;
            out_left   <= res_left;
            state      <= ffba_pkg::S_IDLE;
          end
        end

        default: begin
          state <= ffba_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {
    (ffba_pkg::OUT_DATA_W - ffba_pkg::SIZE_W - ffba_pkg::INDEX_W)'(0),
    out_left,
    out_index
  };

  // The loaded count never passes the table capacity
  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
    else $error("loaded count beyond capacity");

  // The loaded count only ever steps up by one
  a_loaded_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (loaded != $past(loaded))) |->
      (loaded == ffba_pkg::CNT_W'($past(loaded) + 1'b1)))
    else $error("loaded count jumped");

  // The scan only compares entries that have been loaded
  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    ((state == ffba_pkg::S_SCAN) && chk_valid) |-> (chk_idx < loaded))
    else $error("scan compared an unloaded entry");

  // Failure results carry zero index and leftover
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && ((m_axis_tuser == ffba_pkg::ST_NO_FIT) ||
                       (m_axis_tuser == ffba_pkg::ST_FULL))) |-> (m_axis_tdata == '0))
    else $error("failure result with non-zero payload");

endmodule

### src/ffba_size_mem.sv
// Block size store of the first-fit allocator: one write port, one registered read port.
// Depends on ffba_pkg.
module ffba_size_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ffba_pkg::IDX_W-1:0]  wr_addr,
  input  logic [ffba_pkg::SIZE_W-1:0] wr_data,
  input  logic [ffba_pkg::IDX_W-1:0]  rd_addr,
  output logic [ffba_pkg::SIZE_W-1:0] rd_data
);

  logic [ffba_pkg::SIZE_W-1:0] mem [0:ffba_pkg::MAX_BLOCKS-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/ffba_fit_unit.sv
// Shared compare-and-subtract unit: checks one table entry against the request.
// Depends on ffba_pkg.
module ffba_fit_unit (
  input  logic [ffba_pkg::SIZE_W-1:0] block_size,
  input  logic [ffba_pkg::SIZE_W-1:0] request,
  input  logic                        taken,
  output ffba_pkg::fit_res_t          res
);

  always_comb begin
    res.fit      = !taken && (block_size >= request);
    res.leftover = block_size - request;
  end

endmodule

### tb/sv/tb_first_fit_block_allocator.sv
// Self-checking testbench for first_fit_block_allocator: a directed table, then random traffic.
// Depends on ffba_pkg and the allocator RTL; replies are predicted in-bench and checked in order.
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam int N_RANDOM       = 2000;
  localparam int N_DIRECTED     = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // One reply beat as the bench sees it.
  typedef struct packed {
    status_t     status;
    logic [3:0]  index;
    logic [15:0] leftover;
  } alloc_reply_t;

  // One directed request; reply is used only where typed is set.
  typedef struct {
    logic         cmd;
    logic [15:0]  req;
    bit           typed;
    alloc_reply_t reply;
  } stim_row_t;

  localparam alloc_reply_t USE_PREDICTOR = '{ST_LOADED, 4'd0, 16'd0};

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  first_fit_block_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [15:0] size_value
    .s_axis_tuser  (s_axis_tuser),   // [0] command
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [3:0] block_index, [19:4] leftover
    .m_axis_tuser  (m_axis_tuser)    // [1:0] status
  );

  // Bench copy of the allocator state.
  logic [15:0] blk_size  [MAX_BLOCKS];
  bit          blk_taken [MAX_BLOCKS];
  int          n_loaded;

  alloc_reply_t pending_replies [$];
  stim_row_t    directed_rows [N_DIRECTED];

  int mismatches;
  int beats_in;
  int beats_out;
  int status_seen [4];
  int quiet_cycles;
  int burst_left;
  int rdy_mode;
  int rdy_left;

  // 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // First fit: append at the next free slot, or take the lowest free block that is big enough.
  function automatic alloc_reply_t first_fit_predict(input logic cmd, input logic [15:0] req);
    alloc_reply_t r;
    bit           hit;
    r   = '{ST_NO_FIT, 4'd0, 16'd0};
    hit = 1'b0;
    if (cmd == CMD_APPEND) begin
      if (n_loaded >= MAX_BLOCKS) begin
        r.status = ST_FULL;
      end else begin
        blk_size[n_loaded]  = req;
        blk_taken[n_loaded] = 1'b0;
        r.status            = ST_LOADED;
        r.index             = 4'(n_loaded);
        n_loaded++;
      end
    end else begin
      for (int i = 0; i < n_loaded && !hit; i++) begin
        if (!blk_taken[i] && blk_size[i] >= req) begin
          blk_taken[i] = 1'b1;
          r.status     = ST_ALLOCATED;
          r.index      = 4'(i);
          r.leftover   = blk_size[i] - req;
          hit          = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Hold one request beat until it is taken, then record what should come back.
  task automatic send_item(input logic cmd, input logic [15:0] req, input bit typed,
                           input alloc_reply_t typed_reply);
    alloc_reply_t pred;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    // Advance the bench state even where the row carries its own reply.
    pred = first_fit_predict(cmd, req);
    pending_replies.push_back(typed ? typed_reply : pred);
    beats_in++;
  endtask

  // Sender pacing: bursts of random length, random gaps between them, some long bursts.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 16'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  // Random requests: while blocks can still be loaded or taken, mostly appends and
  // allocations sized around a loaded block (exact, just under, just over, zero);
  // otherwise, and for one beat in ten, plain noise over the whole field range.
  task automatic pick_random_item(output logic cmd, output logic [15:0] req);
    bit live;
    int j;
    int k;
    live = (n_loaded < MAX_BLOCKS);
    for (int i = 0; i < n_loaded; i++) begin
      if (!blk_taken[i]) live = 1'b1;
    end
    if (!live || $urandom_range(0, 9) == 0) begin
      cmd = 1'($urandom);
      req = 16'($urandom);
    end else if (n_loaded < MAX_BLOCKS && (n_loaded == 0 || $urandom_range(0, 99) < 45)) begin
      cmd = CMD_APPEND;
      case ($urandom_range(0, 5))
        0:       req = 16'h0000;
        1:       req = 16'hFFFF;
        2, 3:    req = 16'($urandom_range(0, 255));
        default: req = 16'($urandom);
      endcase
    end else begin
      cmd = CMD_ALLOC;
      j   = $urandom_range(0, n_loaded - 1);
      k   = $urandom_range(0, 3);
      case ($urandom_range(0, 5))
        0:       req = blk_size[j];
        1:       req = blk_size[j] - ((blk_size[j] < 16'(k)) ? blk_size[j] : 16'(k));
        2:       req = (blk_size[j] == 16'hFFFF) ? 16'hFFFF : blk_size[j] + 16'd1;
        3:       req = 16'h0000;
        default: req = 16'($urandom);
      endcase
    end
  endtask

  // Receiver: runs of always-ready, coin-flip and mostly-stalled cycles.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = $urandom_range(0, 2);
        rdy_left = $urandom_range(4, 40);
      end
      rdy_left--;
      case (rdy_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom);
        default: m_axis_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Reply checker: every reply beat against the oldest outstanding prediction.
  always @(posedge clk) begin
    alloc_reply_t got;
    alloc_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status   = status_t'(m_axis_tuser);
      got.index    = m_axis_tdata[3:0];
      got.leftover = m_axis_tdata[19:4];
      beats_out++;
      status_seen[int'(m_axis_tuser)]++;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: reply beat with nothing outstanding: status %0d index %0d leftover %h",
                   $realtime, got.status, got.index, got.leftover);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.index !== want.index ||
            got.leftover !== want.leftover) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: reply %0d wrong: status %0d/%0d index %0d/%0d leftover %h/%h (exp/got)",
                     $realtime, beats_out, want.status, got.status, want.index, got.index,
                     want.leftover, got.leftover);
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d replies outstanding",
               quiet_cycles, pending_replies.size());
      $display("tb_first_fit_block_allocator NOT OK");
      $finish;
    end
  end

  initial begin
    logic        cmd;
    logic [15:0] req;
    int          n_taken;
    int          w;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    n_loaded      = 0;
    mismatches    = 0;
    beats_in      = 0;
    beats_out     = 0;
    quiet_cycles  = 0;
    burst_left    = 0;
    rdy_mode      = 0;
    rdy_left      = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (blk_taken[i]) begin
      blk_taken[i] = 1'b0;
      blk_size[i]  = '0;
    end

    // Directed part. Typed replies where they are obvious; the rest go through the predictor.
    directed_rows = '{
      // allocation on an empty table: no fit, both extremes of the request
      '{CMD_ALLOC,  16'h0000, 1'b1, '{ST_NO_FIT,    4'd0, 16'h0000}},
      '{CMD_ALLOC,  16'hFFFF, 1'b1, '{ST_NO_FIT,    4'd0, 16'h0000}},
      // largest, zero-size and unit blocks
      '{CMD_APPEND, 16'hFFFF, 1'b1, '{ST_LOADED,    4'd0, 16'h0000}},
      '{CMD_APPEND, 16'h0000, 1'b1, '{ST_LOADED,    4'd1, 16'h0000}},
      '{CMD_APPEND, 16'h0001, 1'b1, '{ST_LOADED,    4'd2, 16'h0000}},
      // the largest request takes the largest block exactly
      '{CMD_ALLOC,  16'hFFFF, 1'b1, '{ST_ALLOCATED, 4'd0, 16'h0000}},
      // same request again: that block is now taken
      '{CMD_ALLOC,  16'hFFFF, 1'b1, '{ST_NO_FIT,    4'd0, 16'h0000}},
      // zero-size block serves a zero-size request
      '{CMD_ALLOC,  16'h0000, 1'b0, USE_PREDICTOR},
      '{CMD_ALLOC,  16'h0001, 1'b0, USE_PREDICTOR},
      '{CMD_APPEND, 16'h8000, 1'b1, '{ST_LOADED,    4'd3, 16'h0000}},
      '{CMD_APPEND, 16'h1234, 1'b0, USE_PREDICTOR},
      // zero-size request leaves the whole block as leftover
      '{CMD_ALLOC,  16'h0000, 1'b0, USE_PREDICTOR},
      // one over the only free block
      '{CMD_ALLOC,  16'h1235, 1'b0, USE_PREDICTOR},
      '{CMD_APPEND, 16'h7FFF, 1'b0, USE_PREDICTOR},
      // two blocks fit: the lower index must win
      '{CMD_ALLOC,  16'h1234, 1'b0, USE_PREDICTOR},
      '{CMD_ALLOC,  16'h0001, 1'b0, USE_PREDICTOR},
      '{CMD_APPEND, 16'hAAAA, 1'b0, USE_PREDICTOR},
      '{CMD_APPEND, 16'h5555, 1'b0, USE_PREDICTOR},
      // first fit, not best fit: the larger, earlier block is taken
      '{CMD_ALLOC,  16'h5555, 1'b0, USE_PREDICTOR}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      pace_sender();
      send_item(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].typed,
                directed_rows[i].reply);
    end

    // Random part; it fills the table, so appends past capacity hit the full case here.
    for (int n = 0; n < N_RANDOM; n++) begin
      pick_random_item(cmd, req);
      pace_sender();
      send_item(cmd, req, 1'b0, USE_PREDICTOR);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain, then allow a full scan's worth of cycles for any stray beat.
    w = 0;
    while (pending_replies.size() != 0 && w < 100000) begin
      @(posedge clk);
      w++;
    end
    repeat (MAX_BLOCKS + 24) @(posedge clk);

    if (pending_replies.size() != 0) begin
      $display("%0d predicted replies never arrived", pending_replies.size());
      mismatches += pending_replies.size();
    end

    n_taken = 0;
    foreach (blk_taken[i]) n_taken += blk_taken[i];
    $display("Ran %0d request beats (%0d directed), checked %0d replies, %0d mismatches",
             beats_in, N_DIRECTED, beats_out, mismatches);
    $display("Replies: %0d loaded, %0d allocated, %0d no fit, %0d table full; %0d of %0d taken",
             status_seen[ST_LOADED], status_seen[ST_ALLOCATED], status_seen[ST_NO_FIT],
             status_seen[ST_FULL], n_taken, n_loaded);

    if (mismatches == 0) begin
      $display("tb_first_fit_block_allocator OK");
    end else begin
      $display("tb_first_fit_block_allocator NOT OK");
    end
    $finish;
  end

endmodule
